// ===== hw/rtl/rrs_pkg.sv =====
`default_nettype none

package rrs_pkg;

	// Coordinate width (8..16); each register half is used in its low CoordBits bits
	localparam int CoordBits     = 16;
	localparam int HalfBits      = 16;
	localparam int RegBits       = 32;
	localparam int ProdBits      = 2 * CoordBits;
	localparam int StepsPerStage = 4;
	localparam int DivStages     = (ProdBits + StepsPerStage - 1) / StepsPerStage;
	localparam int StepBits      = $clog2(ProdBits + StepsPerStage + 1);
	localparam int Lanes         = 4;

	typedef logic [CoordBits-1:0] coord_t;
	typedef logic [ProdBits-1:0]  prod_t;

	typedef enum logic [2:0] {
		RegRotation = 3'd0,
		RegCrtcOrg  = 3'd1,
		RegModeSize = 3'd2,
		RegSrcSize  = 3'd3,
		RegDestOrg  = 3'd4,
		RegDestSize = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		Ang0   = 2'd0,
		Ang90  = 2'd1,
		Ang180 = 2'd2,
		Ang270 = 2'd3
	} angle_t;

	// rotation_mode bit positions
	localparam int RotReflectX = 2;
	localparam int RotReflectY = 3;
	localparam int RotSelf     = 4;

	// Restoring divider lane: partial remainder and dividend/quotient shift word
	typedef struct packed {
		coord_t rem;
		prod_t  dq;
	} lane_t;

	typedef lane_t lanes_t [Lanes];

	function automatic lane_t div_steps(lane_t a, coord_t d, logic [StepBits-1:0] first);
		logic [CoordBits:0] rr;
		logic [CoordBits:0] diff;
		logic               qb;
		lane_t              t;
		t = a;
		for (int j = 0; j < StepsPerStage; j++) begin
			if (32'(first) + 32'(j) < 32'(ProdBits)) begin
				rr    = {t.rem, t.dq[ProdBits-1]};
				diff  = rr - {1'b0, d};
				qb    = (rr >= {1'b0, d});
				t.dq  = {t.dq[ProdBits-2:0], qb};
				t.rem = qb ? diff[CoordBits-1:0] : rr[CoordBits-1:0];
			end
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rrs_ifs.sv =====
`default_nettype none

interface rrs_box_if;
	logic        valid;
	logic        ready;
	logic [15:0] box_left;
	logic [15:0] box_top;
	logic [15:0] box_right;
	logic [15:0] box_bottom;

	modport source (output valid, box_left, box_top, box_right, box_bottom, input ready);
	modport sink (input valid, box_left, box_top, box_right, box_bottom, output ready);
endinterface

interface rrs_rect_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_x;
	logic [15:0] out_y;
	logic [15:0] out_w;
	logic [15:0] out_h;
	logic        divide_fault;

	modport source (output valid, out_x, out_y, out_w, out_h, divide_fault, input ready);
	modport sink (input valid, out_x, out_y, out_w, out_h, divide_fault, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rotated_rect_scaler.sv =====
`default_nettype none

// Channel   Dir   Payload                                  Transfer when
// boxes     in    box_left/top/right/bottom (s16)          valid & ready
// rects     out   out_x/y/w/h (u16), divide_fault          valid & ready
// cfg       in    cfg_idx, cfg_wdata (32b)                 cfg_we
//
// One rectangle per cycle sustained while rects.ready holds; 3 geometry stages, one
// multiply stage, 8 divider stages at 4 quotient bits each, one output register.
// The divider chain sets the depth. Stages advance independently: a bubble
// collapses even while the output is held, so input is taken while a result waits.
// arst_n clears valid bits and config registers; payload registers are not reset.
module rotated_rect_scaler (
	input  wire                              clk,
	input  wire                              arst_n,
	rrs_box_if.sink                          boxes,
	rrs_rect_if.source                       rects,
	input  wire                              cfg_we,
	input  wire logic [2:0]                  cfg_idx,
	input  wire logic [rrs_pkg::RegBits-1:0] cfg_wdata
);

	localparam int CB = rrs_pkg::CoordBits;
	localparam int HB = rrs_pkg::HalfBits;
	localparam int ND = rrs_pkg::DivStages;

	// ---------------- configuration registers ----------------
	logic [4:0]                  rot_q;
	logic [rrs_pkg::RegBits-1:0] org_q, msz_q, src_q, dof_q, dsz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
			org_q <= '0;
			msz_q <= '0;
			src_q <= '0;
			dof_q <= '0;
			dsz_q <= '0;
		end else if (cfg_we) begin
			case (rrs_pkg::reg_idx_t'(cfg_idx))
				rrs_pkg::RegRotation: rot_q <= cfg_wdata[4:0];
				rrs_pkg::RegCrtcOrg:  org_q <= cfg_wdata;
				rrs_pkg::RegModeSize: msz_q <= cfg_wdata;
				rrs_pkg::RegSrcSize:  src_q <= cfg_wdata;
				rrs_pkg::RegDestOrg:  dof_q <= cfg_wdata;
				rrs_pkg::RegDestSize: dsz_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stages read config directly; the user, not the block, keeps it static in flight.
	rrs_pkg::coord_t crtc_x, crtc_y, hdisp, vdisp, src_w, src_h, dst_x, dst_y, dst_w, dst_h;
	rrs_pkg::coord_t mode_w, mode_h, divx, divy;
	rrs_pkg::angle_t angle;
	logic            refl_x, refl_y, odd;

	assign crtc_x = org_q[CB-1:0];
	assign crtc_y = org_q[HB+CB-1:HB];
	assign hdisp  = msz_q[CB-1:0];
	assign vdisp  = msz_q[HB+CB-1:HB];
	assign src_w  = src_q[CB-1:0];
	assign src_h  = src_q[HB+CB-1:HB];
	assign dst_x  = dof_q[CB-1:0];
	assign dst_y  = dof_q[HB+CB-1:HB];
	assign dst_w  = dsz_q[CB-1:0];
	assign dst_h  = dsz_q[HB+CB-1:HB];

	// Output-side rotation bypasses both the angle and the reflections
	assign angle  = rot_q[rrs_pkg::RotSelf] ? rrs_pkg::Ang0 : rrs_pkg::angle_t'(rot_q[1:0]);
	assign refl_x = rot_q[rrs_pkg::RotReflectX] & ~rot_q[rrs_pkg::RotSelf];
	assign refl_y = rot_q[rrs_pkg::RotReflectY] & ~rot_q[rrs_pkg::RotSelf];
	assign odd    = angle[0];
	assign mode_w = odd ? vdisp : hdisp;
	assign mode_h = odd ? hdisp : vdisp;
	assign divx   = odd ? src_h : src_w;
	assign divy   = odd ? src_w : src_h;

	// ---------------- stall chain ----------------
	// A stage loads when it is empty or when the stage after it loads.
	logic v_s1, v_s2, v_s3, v_s4, v_out_q;
	logic vd_s [ND];
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_out;
	logic ldd_s [ND];

	always_comb begin
		ld_out = !v_out_q || rects.ready;
		ldd_s[ND-1] = !vd_s[ND-1] || ld_out;
		for (int k = ND - 2; k >= 0; k--) begin
			ldd_s[k] = !vd_s[k] || ldd_s[k+1];
		end
		ld_s4 = !v_s4 || ldd_s[0];
		ld_s3 = !v_s3 || ld_s4;
		ld_s2 = !v_s2 || ld_s3;
		ld_s1 = !v_s1 || ld_s2;
	end

	assign boxes.ready = ld_s1;

	// ---------------- s1: origin shift, extents ----------------
	rrs_pkg::coord_t x_s1, y_s1, w_s1, h_s1;
	rrs_pkg::coord_t in_l, in_t, in_r, in_b;

	assign in_l = boxes.box_left[CB-1:0];
	assign in_t = boxes.box_top[CB-1:0];
	assign in_r = boxes.box_right[CB-1:0];
	assign in_b = boxes.box_bottom[CB-1:0];

	always_ff @(posedge clk) begin
		if (ld_s1 && boxes.valid) begin
			x_s1 <= in_l - crtc_x;
			y_s1 <= in_t - crtc_y;
			w_s1 <= in_r - in_l;
			h_s1 <= in_b - in_t;
		end
	end

	// ---------------- s2: reflection against rotated mode size ----------------
	rrs_pkg::coord_t x_s2, y_s2, w_s2, h_s2;

	always_ff @(posedge clk) begin
		if (ld_s2 && v_s1) begin
			x_s2 <= refl_x ? (mode_w - x_s1 - w_s1) : x_s1;
			y_s2 <= refl_y ? (mode_h - y_s1 - h_s1) : y_s1;
			w_s2 <= w_s1;
			h_s2 <= h_s1;
		end
	end

	// ---------------- s3: rotation within the mode ----------------
	rrs_pkg::coord_t x_s3, y_s3, w_s3, h_s3;
	rrs_pkg::coord_t rx_c, ry_c, rw_c, rh_c;

	always_comb begin
		rx_c = x_s2;
		ry_c = y_s2;
		rw_c = w_s2;
		rh_c = h_s2;
		unique case (angle)
			rrs_pkg::Ang90: begin
				rx_c = y_s2;
				ry_c = vdisp - x_s2 - w_s2;
				rw_c = h_s2;
				rh_c = w_s2;
			end
			rrs_pkg::Ang180: begin
				rx_c = hdisp - x_s2 - w_s2;
				ry_c = vdisp - y_s2 - h_s2;
			end
			rrs_pkg::Ang270: begin
				rx_c = hdisp - y_s2 - h_s2;
				ry_c = x_s2;
				rw_c = h_s2;
				rh_c = w_s2;
			end
			rrs_pkg::Ang0: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_s3 && v_s2) begin
			x_s3 <= rx_c;
			y_s3 <= ry_c;
			w_s3 <= rw_c;
			h_s3 <= rh_c;
		end
	end

	// ---------------- s4: scale products, loaded as divider lanes ----------------
	rrs_pkg::lanes_t lanes_s4;

	always_ff @(posedge clk) begin
		if (ld_s4 && v_s3) begin
			lanes_s4[0] <= '{rem: '0, dq: rrs_pkg::ProdBits'(x_s3) * rrs_pkg::ProdBits'(dst_w)};
			lanes_s4[1] <= '{rem: '0, dq: rrs_pkg::ProdBits'(y_s3) * rrs_pkg::ProdBits'(dst_h)};
			lanes_s4[2] <= '{rem: '0, dq: rrs_pkg::ProdBits'(w_s3) * rrs_pkg::ProdBits'(dst_w)};
			lanes_s4[3] <= '{rem: '0, dq: rrs_pkg::ProdBits'(h_s3) * rrs_pkg::ProdBits'(dst_h)};
		end
	end

	// ---------------- divider stages ----------------
	rrs_pkg::lanes_t lanes_sd [ND];
	rrs_pkg::lanes_t lanes_nx [ND];

	for (genvar k = 0; k < ND; k++) begin : g_div
		rrs_pkg::lanes_t lanes_in;
		logic            v_in;

		// first divider stage is fed by the multiply stage
		if (k == 0) begin : g_head
			assign lanes_in = lanes_s4;
			assign v_in     = v_s4;
		end else begin : g_body
			assign lanes_in = lanes_sd[k-1];
			assign v_in     = vd_s[k-1];
		end

		rrs_div_stage u_stage (
			.lanes_a    (lanes_in),
			.divx       (divx),
			.divy       (divy),
			.first_step (rrs_pkg::StepBits'(k * rrs_pkg::StepsPerStage)),
			.lanes_b    (lanes_nx[k])
		);

		always_ff @(posedge clk) begin
			if (ldd_s[k] && v_in) begin
				lanes_sd[k] <= lanes_nx[k];
			end
		end
	end

	// ---------------- output register: offset add, zero-divisor override ----------------
	logic            fault_x, fault_y;
	rrs_pkg::coord_t qx, qy, qw, qh;
	rrs_pkg::coord_t ox_q, oy_q, ow_q, oh_q;
	logic            fault_q;

	assign fault_x = (divx == '0);
	assign fault_y = (divy == '0);
	assign qx      = lanes_sd[ND-1][0].dq[CB-1:0];
	assign qy      = lanes_sd[ND-1][1].dq[CB-1:0];
	assign qw      = lanes_sd[ND-1][2].dq[CB-1:0];
	assign qh      = lanes_sd[ND-1][3].dq[CB-1:0];

	always_ff @(posedge clk) begin
		if (ld_out && vd_s[ND-1]) begin
			ox_q    <= fault_x ? '1 : qx + dst_x;
			oy_q    <= fault_y ? '1 : qy + dst_y;
			ow_q    <= fault_x ? '1 : qw;
			oh_q    <= fault_y ? '1 : qh;
			fault_q <= fault_x | fault_y;
		end
	end

	assign rects.valid        = v_out_q;
	assign rects.out_x        = 16'(ox_q);
	assign rects.out_y        = 16'(oy_q);
	assign rects.out_w        = 16'(ow_q);
	assign rects.out_h        = 16'(oh_q);
	assign rects.divide_fault = fault_q;

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_out_q <= 1'b0;
			for (int k = 0; k < ND; k++) begin
				vd_s[k] <= 1'b0;
			end
		end else begin
			if (ld_s1) v_s1 <= boxes.valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ldd_s[0]) vd_s[0] <= v_s4;
			for (int k = 1; k < ND; k++) begin
				if (ldd_s[k]) vd_s[k] <= vd_s[k-1];
			end
			if (ld_out) v_out_q <= vd_s[ND-1];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rrs_div_stage.sv =====
`default_nettype none

// Four restoring-division steps on each of the four lanes (x, y, w, h).
module rrs_div_stage (
	input  wire rrs_pkg::lanes_t                 lanes_a,
	input  wire rrs_pkg::coord_t                 divx,
	input  wire rrs_pkg::coord_t                 divy,
	input  wire logic [rrs_pkg::StepBits-1:0]    first_step,
	output rrs_pkg::lanes_t                      lanes_b
);

	always_comb begin
		for (int i = 0; i < rrs_pkg::Lanes; i++) begin
			lanes_b[i] = rrs_pkg::div_steps(lanes_a[i], (i % 2 == 0) ? divx : divy, first_step);
		end
	end

endmodule

`default_nettype wire
